// ----- rtl/crp_pkg.sv -----
`default_nettype none

package crp_pkg;

  localparam int unsigned ACC_W = 32;

  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_UP_A  = 8'h41;
  localparam logic [7:0] ASCII_UP_Z  = 8'h5A;
  localparam logic [7:0] ASCII_LO_A  = 8'h61;
  localparam logic [7:0] ASCII_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DIGIT = 2'd1,
    ST_BAD_ROW  = 2'd2,
    ST_BAD_COL  = 2'd3
  } crp_status_t;

  typedef struct packed {
    logic             in_digit;
    logic [ACC_W-1:0] col_acc;
    logic [ACC_W-1:0] row_acc;
    logic             col_seen;
    logic             col_inv;
    logic             row_inv;
  } crp_state_t;

  typedef struct packed {
    crp_status_t      status;
    logic [ACC_W-1:0] column;
    logic [ACC_W-1:0] row;
  } crp_result_t;

endpackage

`default_nettype wire

// ----- rtl/crp_step.sv -----
`default_nettype none

module crp_step import crp_pkg::*; (
  input  wire crp_state_t  st,
  input  wire logic [7:0]  char_code,
  input  wire logic        last,
  output crp_state_t       st_nxt,
  output crp_result_t      res
);

  logic              is_digit;
  logic              digit_part;
  logic [3:0]        dval;
  logic [7:0]        up;
  logic              is_letter;
  logic [4:0]        lval;
  logic [ACC_W+3:0]  row_wide;
  logic [ACC_W+4:0]  col_wide;
  crp_state_t        upd;

  assign is_digit   = (char_code >= ASCII_0) && (char_code <= ASCII_9);
  assign digit_part = st.in_digit | is_digit;
  assign dval       = 4'(char_code - ASCII_0);
  assign up         = ((char_code >= ASCII_LO_A) && (char_code <= ASCII_LO_Z)) ?
                      (char_code - CASE_OFFSET) : char_code;
  assign is_letter  = (up >= ASCII_UP_A) && (up <= ASCII_UP_Z);
  assign lval       = 5'(up - ASCII_UP_A + 8'd1);

  // times ten and times twenty-six as shift-add
  assign row_wide = ({4'd0, st.row_acc} << 3) + ({4'd0, st.row_acc} << 1)
                  + {{ACC_W{1'b0}}, dval};
  assign col_wide = ({5'd0, st.col_acc} << 4) + ({5'd0, st.col_acc} << 3)
                  + ({5'd0, st.col_acc} << 1) + {{ACC_W{1'b0}}, lval};

  always_comb begin
    upd          = st;
    upd.in_digit = digit_part;
    if (digit_part) begin
      if (!is_digit) begin
        upd.row_inv = 1'b1;
      end else if (!st.row_inv) begin
        if (row_wide[ACC_W+3:ACC_W] != 4'd0) begin
          upd.row_inv = 1'b1;
        end else begin
          upd.row_acc = row_wide[ACC_W-1:0];
        end
      end
    end else begin
      upd.col_seen = 1'b1;
      if (!is_letter) begin
        upd.col_inv = 1'b1;
      end else if (!st.col_inv) begin
        if (col_wide[ACC_W+4:ACC_W] != 5'd0) begin
          upd.col_inv = 1'b1;
        end else begin
          upd.col_acc = col_wide[ACC_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res = '{status: ST_OK, column: '0, row: '0};
    if (!upd.in_digit) begin
      res.status = ST_NO_DIGIT;
    end else if (upd.row_inv || (upd.row_acc == '0)) begin
      res.status = ST_BAD_ROW;
    end else if (!upd.col_seen || upd.col_inv || (upd.col_acc == '0)) begin
      res.status = ST_BAD_COL;
    end else begin
      res.column = upd.col_acc - 1'b1;
      res.row    = upd.row_acc - 1'b1;
    end
  end

  assign st_nxt = last ? crp_state_t'('0) : upd;

endmodule

`default_nettype wire

// ----- rtl/crp_out_buf.sv -----
`default_nettype none

module crp_out_buf import crp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  input  wire crp_result_t up_word,
  output logic             up_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output crp_result_t      out_word
);

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  crp_result_t out_word_r, out_word_nxt;
  crp_result_t skid_word_r, skid_word_nxt;

  assign up_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = out_word_r;
    skid_word_nxt  = skid_word_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = up_valid;
        out_word_nxt  = up_word;
      end
    end else if (up_valid && !skid_valid_r) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = up_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/cell_reference_parser.sv -----
// path: an accepted word is held in s0, its result word in the output buffer (out_*)
// throughput: one character word per cycle unless a last word waits on a full buffer,
// set by the accumulator update (shift-add times ten or twenty-six plus overflow check)
// reset: rst_n synchronous, active low; clears parse state and all valid flags
// no memory, no clearing pass after reset
`default_nettype none

module cell_reference_parser import crp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_column,
  output logic [31:0]      out_row
);

  logic        s0_valid_r, s0_valid_nxt;
  logic [7:0]  s0_char_r;
  logic        s0_last_r;
  crp_state_t  st_r, st_nxt, step_nxt;
  crp_result_t step_res;
  crp_result_t buf_word;
  logic        buf_ready;
  logic        advance;

  crp_step u_step (
    .st        (st_r),
    .char_code (s0_char_r),
    .last      (s0_last_r),
    .st_nxt    (step_nxt),
    .res       (step_res)
  );

  crp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (advance && s0_last_r),
    .up_word   (step_res),
    .up_ready  (buf_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (buf_word)
  );

  assign advance      = s0_valid_r && (!s0_last_r || buf_ready);
  assign in_ready     = !s0_valid_r || advance;
  assign s0_valid_nxt = in_ready ? in_valid : s0_valid_r;
  assign st_nxt       = advance ? step_nxt : st_r;

  assign out_status = buf_word.status;
  assign out_column = buf_word.column;
  assign out_row    = buf_word.row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      st_r       <= '0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      st_r       <= st_nxt;
    end
    if (in_valid && in_ready) begin
      s0_char_r <= in_char_code;
      s0_last_r <= in_last;
    end
  end

  // ok results never carry the all-ones index
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> (out_column != '1) && (out_row != '1))
    else $error("ok result out of range");

  // error results carry zero indexes
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_column == '0) && (out_row == '0))
    else $error("error result with nonzero index");

  // the last word of a reference returns parse state to reset
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s0_last_r |=> (st_r == '0))
    else $error("parse state not cleared after last word");

  // a held last word only waits on the output buffer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !advance |=> s0_valid_r && $stable(s0_char_r) && $stable(s0_last_r))
    else $error("stalled word lost");

endmodule

`default_nettype wire
